### hw/rtl/mono_page_framebuffer_draw_core_defines.svh
// assertion macros for the page framebuffer draw core
// no dependencies; included by the top level only
`ifndef MONO_PAGE_FRAMEBUFFER_DRAW_CORE_DEFINES_SVH
`define MONO_PAGE_FRAMEBUFFER_DRAW_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define MPFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MPFD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MPFD_ASSERT(lbl, prop, msg)
`define MPFD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### hw/rtl/mpfd_pkg.sv
// shared types, constants and font table of the page framebuffer draw core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mpfd_pkg;

  localparam int DISPLAY_WIDTH_DEF  = 128;
  localparam int DISPLAY_HEIGHT_DEF = 64;
  localparam int MAX_SCALE_DEF      = 8;
  localparam int ADDR_MAX_W         = 16;
  localparam int COORD_W            = 14;
  localparam int QUEUE_DEPTH        = 2;
  localparam int RAM_WIDTH_DEF      = 8;
  localparam int RAM_DEPTH_DEF      = 1024;
  localparam logic [7:0] CODE_LOW   = 8'h20;
  localparam logic [7:0] CODE_HIGH  = 8'h7F;

  typedef enum logic [2:0] {
    REQ_CLEAR_ALL, REQ_CLEAR_ROW, REQ_SET_PIXEL, REQ_CLEAR_PIXEL,
    REQ_INVERT_RECT, REQ_ROW_GLYPH, REQ_SCALED_GLYPH, REQ_READ
  } req_type_e;

  typedef enum logic [2:0] {
    CMD_NOP, CMD_CLRALL, CMD_CLRROW, CMD_PIXEL,
    CMD_RECT, CMD_ROWG, CMD_SCALEG, CMD_READ
  } cmd_op_e;

  typedef enum logic [1:0] {PIX_CLR, PIX_SET, PIX_XOR} pix_op_e;

  typedef struct packed {
    cmd_op_e                    op;
    pix_op_e                    pmode;
    logic [ADDR_MAX_W-1:0]      addr;
    logic [7:0]                 mask;
    logic signed [COORD_W-1:0]  x0;
    logic signed [COORD_W-1:0]  x1;
    logic signed [COORD_W-1:0]  y0;
    logic signed [COORD_W-1:0]  y1;
    logic [47:0]                glyph;
    logic [4:0]                 scale;
  } cmd_t;

  // column 0 in the top byte
  localparam logic [47:0] FONT [96] = '{
    48'h000000000000, 48'h00005F000000, 48'h000700070000, 48'h147F147F1400,
    48'h242A7F2A1200, 48'h231308646200, 48'h364955225000, 48'h000503000000,
    48'h001C22410000, 48'h0041221C0000, 48'h14083E081400, 48'h08083E080800,
    48'h005030000000, 48'h080808080800, 48'h006060000000, 48'h201008040200,
    48'h3E5149453E00, 48'h00427F400000, 48'h426151494600, 48'h2141454B3100,
    48'h1814127F1000, 48'h274545453900, 48'h3C4A49493000, 48'h017109050300,
    48'h364949493600, 48'h064949291E00, 48'h003636000000, 48'h005636000000,
    48'h000814224100, 48'h141414141400, 48'h412214080000, 48'h020151090600,
    48'h324979413E00, 48'h7E1111117E00, 48'h7F4949493600, 48'h3E4141412200,
    48'h7F4141221C00, 48'h7F4949494100, 48'h7F0909090100, 48'h3E4149497A00,
    48'h7F0808087F00, 48'h00417F410000, 48'h2040413F0100, 48'h7F0814224100,
    48'h7F4040404000, 48'h7F020C027F00, 48'h7F0408107F00, 48'h3E4141413E00,
    48'h7F0909090600, 48'h3E4151215E00, 48'h7F0919294600, 48'h464949493100,
    48'h01017F010100, 48'h3F4040403F00, 48'h1F2040201F00, 48'h3F4038403F00,
    48'h631408146300, 48'h070870080700, 48'h615149454300, 48'h007F41410000,
    48'h020408102000, 48'h0041417F0000, 48'h040201020400, 48'h404040404000,
    48'h000102040000, 48'h205454547800, 48'h7F4844443800, 48'h384444442000,
    48'h384444487F00, 48'h385454541800, 48'h087E09010200, 48'h0C5252523E00,
    48'h7F0804047800, 48'h00447D400000, 48'h2040443D0000, 48'h7F1028440000,
    48'h00417F400000, 48'h7C0418047800, 48'h7C0804047800, 48'h384444443800,
    48'h7C1414140800, 48'h081414187C00, 48'h7C0804040800, 48'h485454542000,
    48'h043F44402000, 48'h3C4040207C00, 48'h1C2040201C00, 48'h3C4030403C00,
    48'h442810284400, 48'h0C5050503C00, 48'h4464544C4400, 48'h000836410000,
    48'h00007F000000, 48'h004136080000, 48'h080408100800, 48'h000000000000
  };

  function automatic logic [47:0] glyph_bits(input logic [7:0] code);
    logic [7:0] idx;
    idx = code - CODE_LOW;
    if (code < CODE_LOW || code > CODE_HIGH) begin
      idx = CODE_HIGH - CODE_LOW;
    end
    return FONT[idx[6:0]];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/mono_page_framebuffer_draw_core.sv
// top level of the page framebuffer draw core: front end, queue, sequencer
// depends on mpfd_pkg, mpfd_front, mpfd_queue, mpfd_back and the defines header
//
//   channel | direction | handshake             | word
//   request | in        | in_valid_i/in_stall_o | req_type_i .. byte_index_i
//   result  | out       | out_valid_o/out_stall_i | read_data_o, is_read_o
//
// invert rect does a ram read-modify-write per byte column touched; scaled glyph
// walks each glyph bit and, for a set bit, each pixel of its block, with a ram
// read-modify-write for each on-screen pixel
// after reset the ram is zeroed with the request side stalled
// the queue takes two requests while the sequencer or the result side stalls
`timescale 1ns / 1ps
`default_nettype none
`include "mono_page_framebuffer_draw_core_defines.svh"
module mono_page_framebuffer_draw_core #(
  parameter int DISPLAY_WIDTH  = mpfd_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = mpfd_pkg::DISPLAY_HEIGHT_DEF,
  parameter int MAX_SCALE      = mpfd_pkg::MAX_SCALE_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         req_type_i,
  input  wire logic signed [11:0] pos_x_i,
  input  wire logic signed [11:0] pos_y_i,
  input  wire logic signed [11:0] rect_width_i,
  input  wire logic signed [11:0] rect_height_i,
  input  wire logic signed [7:0]  page_row_i,
  input  wire logic [7:0]         char_code_i,
  input  wire logic [3:0]         glyph_scale_i,
  input  wire logic [9:0]         byte_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              read_data_o,
  output logic                    is_read_o
);
  mpfd_pkg::cmd_t push_cmd, head_cmd;
  logic           q_push, q_pop, q_full, q_empty, init_busy;

  mpfd_front #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .MAX_SCALE      (MAX_SCALE)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .blocked_i     (q_full || init_busy),
    .in_stall_o    (in_stall_o),
    .push_o        (q_push),
    .req_type_i    (req_type_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .page_row_i    (page_row_i),
    .char_code_i   (char_code_i),
    .glyph_scale_i (glyph_scale_i),
    .byte_index_i  (byte_index_i),
    .cmd_o         (push_cmd)
  );

  mpfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .pop_i   (q_pop),
    .head_o  (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mpfd_back #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o),
    .is_read_o   (is_read_o)
  );

  `MPFD_ASSERT(a_queue_no_overflow, q_push |-> !q_full, "queue overflow")
  `MPFD_ASSERT(a_queue_no_underflow, q_pop |-> !q_empty, "queue underflow")
  `MPFD_ASSERT(a_no_accept_in_init, init_busy |-> !q_push, "request taken during ram clear")
  `MPFD_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result during reset")
endmodule
`default_nettype wire

### hw/rtl/mpfd_ram.sv
// generic single write, single read port ram with registered read
// no dependencies beyond mpfd_pkg defaults
`timescale 1ns / 1ps
`default_nettype none
module mpfd_ram #(
  parameter int WIDTH = mpfd_pkg::RAM_WIDTH_DEF,
  parameter int DEPTH = mpfd_pkg::RAM_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### hw/rtl/mpfd_front.sv
// front end: accepts request words, clips and classifies them into commands
// depends on mpfd_pkg
`timescale 1ns / 1ps
`default_nettype none
module mpfd_front #(
  parameter int DISPLAY_WIDTH  = mpfd_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = mpfd_pkg::DISPLAY_HEIGHT_DEF,
  parameter int MAX_SCALE      = mpfd_pkg::MAX_SCALE_DEF
) (
  input  wire logic               in_valid_i,
  input  wire logic               blocked_i,
  output logic                    in_stall_o,
  output logic                    push_o,
  input  wire logic [2:0]         req_type_i,
  input  wire logic signed [11:0] pos_x_i,
  input  wire logic signed [11:0] pos_y_i,
  input  wire logic signed [11:0] rect_width_i,
  input  wire logic signed [11:0] rect_height_i,
  input  wire logic signed [7:0]  page_row_i,
  input  wire logic [7:0]         char_code_i,
  input  wire logic [3:0]         glyph_scale_i,
  input  wire logic [9:0]         byte_index_i,
  output mpfd_pkg::cmd_t          cmd_o
);
  localparam int PC    = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE = DISPLAY_WIDTH * PC;
  localparam int AW    = $clog2(STORE);
  localparam int CW    = mpfd_pkg::COORD_W;
  localparam int ADW   = mpfd_pkg::ADDR_MAX_W;
  localparam logic signed [CW-1:0] W_S  = CW'(DISPLAY_WIDTH);
  localparam logic signed [CW-1:0] H_S  = CW'(DISPLAY_HEIGHT);
  localparam logic signed [CW-1:0] PC_S = CW'(PC);
  localparam logic [4:0] SMAX = 5'(MAX_SCALE);

  logic signed [CW-1:0] x_s, y_s, w_s, h_s, xe, ye, x0c, y0c, xlim, ylim, page_sel;
  logic                 page_ok, pix_ok, rect_empty, read_ok;
  logic [AW-1:0]        base, pix_addr;
  logic [4:0]           scale_c;
  mpfd_pkg::req_type_e  req;

  assign in_stall_o = blocked_i;
  assign push_o     = in_valid_i && !blocked_i;

  always_comb begin
    req  = mpfd_pkg::req_type_e'(req_type_i);
    x_s  = CW'(pos_x_i);
    y_s  = CW'(pos_y_i);
    w_s  = CW'(rect_width_i);
    h_s  = CW'(rect_height_i);
    xe   = x_s + w_s;
    ye   = y_s + h_s;
    x0c  = (x_s < 0) ? '0 : x_s;
    y0c  = (y_s < 0) ? '0 : y_s;
    xlim = (xe > W_S) ? W_S : xe;
    ylim = (ye > H_S) ? H_S : ye;
    rect_empty = (w_s <= 0) || (h_s <= 0) || (x0c >= xlim) || (y0c >= ylim);

    scale_c = {1'b0, glyph_scale_i};
    if (scale_c == 5'd0) begin
      scale_c = 5'd1;
    end
    if (scale_c > SMAX) begin
      scale_c = SMAX;
    end

    case (req)
      mpfd_pkg::REQ_CLEAR_ROW, mpfd_pkg::REQ_ROW_GLYPH: page_sel = CW'(page_row_i);
      default: page_sel = y_s >>> 3;
    endcase
    page_ok  = (page_sel >= 0) && (page_sel < PC_S);
    base     = AW'($unsigned(page_sel)) * AW'(DISPLAY_WIDTH);
    pix_ok   = (x_s >= 0) && (x_s < W_S) && (y_s >= 0) && (y_s < H_S);
    pix_addr = base + AW'($unsigned(x_s));
    read_ok  = int'(byte_index_i) < STORE;

    cmd_o       = '0;
    cmd_o.op    = mpfd_pkg::CMD_NOP;
    cmd_o.pmode = mpfd_pkg::PIX_SET;
    cmd_o.glyph = mpfd_pkg::glyph_bits(char_code_i);
    cmd_o.scale = scale_c;
    cmd_o.x0    = x_s;
    cmd_o.y0    = y_s;
    case (req)
      mpfd_pkg::REQ_CLEAR_ALL: cmd_o.op = mpfd_pkg::CMD_CLRALL;
      mpfd_pkg::REQ_CLEAR_ROW: begin
        if (page_ok) begin
          cmd_o.op   = mpfd_pkg::CMD_CLRROW;
          cmd_o.addr = ADW'(base);
        end
      end
      mpfd_pkg::REQ_SET_PIXEL, mpfd_pkg::REQ_CLEAR_PIXEL: begin
        if (pix_ok) begin
          cmd_o.op    = mpfd_pkg::CMD_PIXEL;
          cmd_o.pmode = (req == mpfd_pkg::REQ_SET_PIXEL) ? mpfd_pkg::PIX_SET
                                                         : mpfd_pkg::PIX_CLR;
          cmd_o.addr  = ADW'(pix_addr);
          cmd_o.mask  = 8'd1 << y_s[2:0];
        end
      end
      mpfd_pkg::REQ_INVERT_RECT: begin
        if (!rect_empty) begin
          cmd_o.op = mpfd_pkg::CMD_RECT;
          cmd_o.x0 = x0c;
          cmd_o.x1 = xlim - CW'(1);
          cmd_o.y0 = y0c;
          cmd_o.y1 = ylim - CW'(1);
        end
      end
      mpfd_pkg::REQ_ROW_GLYPH: begin
        if (page_ok) begin
          cmd_o.op   = mpfd_pkg::CMD_ROWG;
          cmd_o.addr = ADW'(base);
        end
      end
      mpfd_pkg::REQ_SCALED_GLYPH: begin
        if (scale_c == 5'd1 && y_s[2:0] == 3'd0) begin
          if (page_ok) begin
            cmd_o.op   = mpfd_pkg::CMD_ROWG;
            cmd_o.addr = ADW'(base);
          end
        end else begin
          cmd_o.op = mpfd_pkg::CMD_SCALEG;
        end
      end
      mpfd_pkg::REQ_READ: begin
        cmd_o.op   = mpfd_pkg::CMD_READ;
        cmd_o.addr = read_ok ? ADW'(byte_index_i) : '0;
        cmd_o.mask = read_ok ? 8'hFF : 8'h00;
      end
      default: cmd_o.op = mpfd_pkg::CMD_NOP;
    endcase
  end
endmodule
`default_nettype wire

### hw/rtl/mpfd_queue.sv
// short command queue between front end and drawing sequencer
// depends on mpfd_pkg
`timescale 1ns / 1ps
`default_nettype none
module mpfd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mpfd_pkg::cmd_t cmd_i,
  input  wire logic           pop_i,
  output mpfd_pkg::cmd_t      head_o,
  output logic                full_o,
  output logic                empty_o
);
  localparam int D  = mpfd_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CNW = $clog2(D + 1);

  mpfd_pkg::cmd_t mem_q [D];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CNW-1:0] cnt_q;

  assign head_o  = mem_q[rd_q];
  assign full_o  = cnt_q == CNW'(D);
  assign empty_o = cnt_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(D - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(D - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNW'(1);
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/mpfd_back.sv
// drawing sequencer: runs commands against the frame ram, holds the result word
// depends on mpfd_pkg and mpfd_ram
`timescale 1ns / 1ps
`default_nettype none
module mpfd_back #(
  parameter int DISPLAY_WIDTH  = mpfd_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = mpfd_pkg::DISPLAY_HEIGHT_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mpfd_pkg::cmd_t head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                init_busy_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [7:0]          read_data_o,
  output logic                is_read_o
);
  localparam int PC    = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE = DISPLAY_WIDTH * PC;
  localparam int AW    = $clog2(STORE);
  localparam int CW    = mpfd_pkg::COORD_W;
  localparam logic signed [CW-1:0] W_S = CW'(DISPLAY_WIDTH);
  localparam logic signed [CW-1:0] H_S = CW'(DISPLAY_HEIGHT);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLR, ST_ROWG, ST_RECT, ST_SGL, ST_RMW, ST_READ, ST_DONE
  } st_e;

  st_e                  st_q, ret_q;
  mpfd_pkg::cmd_t       cmd_q;
  logic [AW-1:0]        cnt_q, end_q, rmw_addr_q;
  logic [7:0]           rmw_mask_q, res_data_q;
  mpfd_pkg::pix_op_e    rmw_op_q;
  logic                 res_rd_q;
  logic [2:0]           k_q, gc_q, gr_q;
  logic [4:0]           i_q, j_q;
  logic signed [CW-1:0] col_q, page_q, bx_q, by_q;

  logic                 we;
  logic [AW-1:0]        waddr, raddr, rect_addr, sgl_addr, rowg_addr;
  logic [7:0]           wdata, rdata, rect_mask, sgl_mask, rmw_data;
  logic signed [CW-1:0] pg_lo, pg_hi, px, py, cx;
  logic [2:0]           lo, hi;
  logic [47:0]          gl_sh;
  logic [4:0]           s_m1;
  logic                 glyph_bit, px_on, blk_last, sgl_last, cx_ok, rect_last;

  mpfd_ram #(.WIDTH(8), .DEPTH(STORE)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign pop_o       = (st_q == ST_IDLE) && !empty_i;
  assign init_busy_o = st_q == ST_INIT;

  always_comb begin
    pg_lo     = cmd_q.y0 >>> 3;
    pg_hi     = cmd_q.y1 >>> 3;
    lo        = (page_q == pg_lo) ? cmd_q.y0[2:0] : 3'd0;
    hi        = (page_q == pg_hi) ? cmd_q.y1[2:0] : 3'd7;
    rect_mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
    rect_addr = AW'($unsigned(page_q)) * AW'(DISPLAY_WIDTH) + AW'($unsigned(col_q));
    rect_last = (col_q == cmd_q.x1) && (page_q == pg_hi);

    glyph_bit = cmd_q.glyph[6'(6'd40 - {gc_q, 3'b000} + {3'b000, gr_q})];
    px        = bx_q + CW'(i_q);
    py        = by_q + CW'(j_q);
    px_on     = (px >= 0) && (px < W_S) && (py >= 0) && (py < H_S);
    sgl_addr  = AW'($unsigned(py >>> 3)) * AW'(DISPLAY_WIDTH) + AW'($unsigned(px));
    sgl_mask  = 8'd1 << py[2:0];
    s_m1      = cmd_q.scale - 5'd1;
    blk_last  = (i_q == s_m1) && (j_q == s_m1);
    sgl_last  = (gc_q == 3'd5) && (gr_q == 3'd7) && (!glyph_bit || blk_last);

    cx        = cmd_q.x0 + CW'(k_q);
    cx_ok     = (cx >= 0) && (cx < W_S);
    rowg_addr = cmd_q.addr[AW-1:0] + AW'($unsigned(cx));
    gl_sh     = cmd_q.glyph << {k_q, 3'b000};

    case (rmw_op_q)
      mpfd_pkg::PIX_CLR: rmw_data = rdata & ~rmw_mask_q;
      mpfd_pkg::PIX_SET: rmw_data = rdata | rmw_mask_q;
      mpfd_pkg::PIX_XOR: rmw_data = rdata ^ rmw_mask_q;
      default:           rmw_data = rdata;
    endcase

    we    = 1'b0;
    waddr = rmw_addr_q;
    wdata = '0;
    case (st_q)
      ST_INIT, ST_CLR: begin
        we    = 1'b1;
        waddr = cnt_q;
      end
      ST_ROWG: begin
        we    = cx_ok;
        waddr = rowg_addr;
        wdata = gl_sh[47:40];
      end
      ST_RMW: begin
        we    = 1'b1;
        wdata = rmw_data;
      end
      default: we = 1'b0;
    endcase

    case (st_q)
      ST_IDLE: raddr = head_i.addr[AW-1:0];
      ST_RECT: raddr = rect_addr;
      ST_SGL:  raddr = sgl_addr;
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_INIT;
      ret_q       <= ST_DONE;
      cnt_q       <= '0;
      end_q       <= AW'(STORE - 1);
      out_valid_o <= 1'b0;
      read_data_o <= '0;
      is_read_o   <= 1'b0;
      res_rd_q    <= 1'b0;
      k_q         <= '0;
      gc_q        <= '0;
      gr_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
    end else begin
      if (out_valid_o && !out_stall_i && st_q != ST_DONE) begin
        out_valid_o <= 1'b0;
      end
      case (st_q)
        ST_INIT: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == AW'(STORE - 1)) begin
            st_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!empty_i) begin
            cmd_q      <= head_i;
            res_data_q <= '0;
            res_rd_q   <= 1'b0;
            case (head_i.op)
              mpfd_pkg::CMD_CLRALL: begin
                cnt_q <= '0;
                end_q <= AW'(STORE - 1);
                st_q  <= ST_CLR;
              end
              mpfd_pkg::CMD_CLRROW: begin
                cnt_q <= head_i.addr[AW-1:0];
                end_q <= head_i.addr[AW-1:0] + AW'(DISPLAY_WIDTH - 1);
                st_q  <= ST_CLR;
              end
              mpfd_pkg::CMD_PIXEL: begin
                rmw_addr_q <= head_i.addr[AW-1:0];
                rmw_mask_q <= head_i.mask;
                rmw_op_q   <= head_i.pmode;
                ret_q      <= ST_DONE;
                st_q       <= ST_RMW;
              end
              mpfd_pkg::CMD_RECT: begin
                col_q  <= head_i.x0;
                page_q <= head_i.y0 >>> 3;
                st_q   <= ST_RECT;
              end
              mpfd_pkg::CMD_ROWG: begin
                k_q  <= '0;
                st_q <= ST_ROWG;
              end
              mpfd_pkg::CMD_SCALEG: begin
                gc_q <= '0;
                gr_q <= '0;
                i_q  <= '0;
                j_q  <= '0;
                bx_q <= head_i.x0;
                by_q <= head_i.y0;
                st_q <= ST_SGL;
              end
              mpfd_pkg::CMD_READ: st_q <= ST_READ;
              default:            st_q <= ST_DONE;
            endcase
          end
        end
        ST_CLR: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == end_q) begin
            st_q <= ST_DONE;
          end
        end
        ST_ROWG: begin
          k_q <= k_q + 3'd1;
          if (k_q == 3'd5) begin
            st_q <= ST_DONE;
          end
        end
        ST_RECT: begin
          rmw_addr_q <= rect_addr;
          rmw_mask_q <= rect_mask;
          rmw_op_q   <= mpfd_pkg::PIX_XOR;
          ret_q      <= rect_last ? ST_DONE : ST_RECT;
          if (col_q == cmd_q.x1) begin
            col_q  <= cmd_q.x0;
            page_q <= page_q + CW'(1);
          end else begin
            col_q <= col_q + CW'(1);
          end
          st_q <= ST_RMW;
        end
        ST_RMW: st_q <= ret_q;
        ST_SGL: begin
          if (glyph_bit && !blk_last) begin
            if (i_q == s_m1) begin
              i_q <= '0;
              j_q <= j_q + 5'd1;
            end else begin
              i_q <= i_q + 5'd1;
            end
          end else begin
            i_q <= '0;
            j_q <= '0;
            if (gr_q == 3'd7) begin
              gr_q <= '0;
              gc_q <= gc_q + 3'd1;
              by_q <= cmd_q.y0;
              bx_q <= bx_q + CW'(cmd_q.scale);
            end else begin
              gr_q <= gr_q + 3'd1;
              by_q <= by_q + CW'(cmd_q.scale);
            end
          end
          if (glyph_bit && px_on) begin
            rmw_addr_q <= sgl_addr;
            rmw_mask_q <= sgl_mask;
            rmw_op_q   <= mpfd_pkg::PIX_SET;
            ret_q      <= sgl_last ? ST_DONE : ST_SGL;
            st_q       <= ST_RMW;
          end else if (sgl_last) begin
            st_q <= ST_DONE;
          end
        end
        ST_READ: begin
          res_data_q <= rdata & cmd_q.mask;
          res_rd_q   <= 1'b1;
          st_q       <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o <= 1'b1;
            read_data_o <= res_data_q;
            is_read_o   <= res_rd_q;
            st_q        <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
